@@ rtl/core/dpt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dpt_pkg;

   // Q0.16 fixed point
   localparam int PRED_BITS   = 16;
   localparam int MAX_RESULTS = 16;
   localparam logic [PRED_BITS:0] PRED_ONE = {1'b1, {PRED_BITS{1'b0}}};

   // request kinds
   localparam logic [2:0] REQ_HELLO = 3'd0;
   localparam logic [2:0] REQ_ACK   = 3'd1;
   localparam logic [2:0] REQ_ACK2  = 3'd2;
   localparam logic [2:0] REQ_ENTRY = 3'd3;
   localparam logic [2:0] REQ_READ  = 3'd4;

   // response status codes
   localparam logic [2:0] ST_UPDATED = 3'd0;
   localparam logic [2:0] ST_ADDED   = 3'd1;
   localparam logic [2:0] ST_SAME    = 3'd2;
   localparam logic [2:0] ST_OWN     = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;
   localparam logic [2:0] ST_EMPTY   = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_OWN   = 2'd0;
   localparam logic [1:0] CSR_PINIT = 2'd1;
   localparam logic [1:0] CSR_GAMMA = 2'd2;
   localparam logic [1:0] CSR_BETA  = 2'd3;

   // datapath operations
   localparam logic [4:0] OP_NOP   = 5'd0;
   localparam logic [4:0] OP_LOAD  = 5'd1;
   localparam logic [4:0] OP_PCMP  = 5'd2;
   localparam logic [4:0] OP_MCMP  = 5'd3;
   localparam logic [4:0] OP_MEND  = 5'd4;
   localparam logic [4:0] OP_POW   = 5'd5;
   localparam logic [4:0] OP_AGE   = 5'd6;
   localparam logic [4:0] OP_HELLO = 5'd7;
   localparam logic [4:0] OP_ACK   = 5'd8;
   localparam logic [4:0] OP_ACK2  = 5'd9;
   localparam logic [4:0] OP_TMUL1 = 5'd10;
   localparam logic [4:0] OP_TMUL2 = 5'd11;
   localparam logic [4:0] OP_TFIN  = 5'd12;
   localparam logic [4:0] OP_TSKIP = 5'd13;
   localparam logic [4:0] OP_RDOUT = 5'd14;
   localparam logic [4:0] OP_EMPTY = 5'd15;

   typedef struct packed {
      logic [4:0] op;
   } cmd_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic       pred_empty;
      logic       meet_empty;
      logic       pred_last;
      logic       meet_last;
      logic       read_last;
      logic       armed;
      logic       own_hit;
      logic       pow_done;
      logic       out_busy;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/core/dpt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dpt_ctrl
   import dpt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DISP  = 5'd1;
   localparam logic [4:0] S_PWAIT = 5'd2;
   localparam logic [4:0] S_PCMP  = 5'd3;
   localparam logic [4:0] S_PFIN  = 5'd4;
   localparam logic [4:0] S_MWAIT = 5'd5;
   localparam logic [4:0] S_MCMP  = 5'd6;
   localparam logic [4:0] S_MEND  = 5'd7;
   localparam logic [4:0] S_POW   = 5'd8;
   localparam logic [4:0] S_AWAIT = 5'd9;
   localparam logic [4:0] S_ACMP  = 5'd10;
   localparam logic [4:0] S_AFIN  = 5'd11;
   localparam logic [4:0] S_TMUL1 = 5'd12;
   localparam logic [4:0] S_TMUL2 = 5'd13;
   localparam logic [4:0] S_TSKIP = 5'd14;
   localparam logic [4:0] S_RWAIT = 5'd15;
   localparam logic [4:0] S_ROUT  = 5'd16;
   localparam logic [4:0] S_EMPTY = 5'd17;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (sts.req_type)
               REQ_HELLO, REQ_ACK2: state_in = sts.pred_empty ? S_PFIN : S_PWAIT;
               REQ_ACK:             state_in = sts.meet_empty ? S_MEND : S_MWAIT;
               REQ_ENTRY: state_in = (!sts.armed || sts.own_hit) ? S_TSKIP : S_TMUL1;
               REQ_READ:  state_in = sts.pred_empty ? S_EMPTY : S_RWAIT;
               default:   state_in = S_EMPTY;
            endcase
         end
         S_PWAIT: state_in = S_PCMP;
         S_PCMP: begin
            cmd.op   = OP_PCMP;
            state_in = sts.pred_last ? S_PFIN : S_PWAIT;
         end
         S_PFIN: begin
            if (!sts.out_busy) begin
               case (sts.req_type)
                  REQ_HELLO: cmd.op = OP_HELLO;
                  REQ_ACK2:  cmd.op = OP_ACK2;
                  default:   cmd.op = OP_TFIN;
               endcase
               state_in = S_IDLE;
            end
         end
         S_MWAIT: state_in = S_MCMP;
         S_MCMP: begin
            cmd.op   = OP_MCMP;
            state_in = sts.meet_last ? S_MEND : S_MWAIT;
         end
         S_MEND: begin
            cmd.op   = OP_MEND;
            state_in = S_POW;
         end
         S_POW: begin
            cmd.op = OP_POW;
            if (sts.pow_done) begin
               state_in = sts.pred_empty ? S_AFIN : S_AWAIT;
            end
         end
         S_AWAIT: state_in = S_ACMP;
         S_ACMP: begin
            cmd.op   = OP_AGE;
            state_in = sts.pred_last ? S_AFIN : S_AWAIT;
         end
         S_AFIN: begin
            if (!sts.out_busy) begin
               cmd.op   = OP_ACK;
               state_in = S_IDLE;
            end
         end
         S_TMUL1: begin
            cmd.op   = OP_TMUL1;
            state_in = S_TMUL2;
         end
         S_TMUL2: begin
            cmd.op   = OP_TMUL2;
            state_in = sts.pred_empty ? S_PFIN : S_PWAIT;
         end
         S_TSKIP: begin
            if (!sts.out_busy) begin
               cmd.op   = OP_TSKIP;
               state_in = S_IDLE;
            end
         end
         S_RWAIT: state_in = S_ROUT;
         S_ROUT: begin
            if (!sts.out_busy) begin
               cmd.op   = OP_RDOUT;
               state_in = sts.read_last ? S_IDLE : S_RWAIT;
            end
         end
         S_EMPTY: begin
            if (!sts.out_busy) begin
               cmd.op   = OP_EMPTY;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/dpt_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dpt_dpath
   import dpt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int MEET_DEPTH  = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   output sts_type           sts,
   input  wire logic [111:0] req_tdata,
   input  wire logic [2:0]   req_tuser,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [47:0]       rsp_tdata,
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast
);

   localparam int TIDX_W = $clog2(TABLE_DEPTH);
   localparam int MIDX_W = $clog2(MEET_DEPTH);
   localparam int TCNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int MCNT_W = $clog2(MEET_DEPTH + 1);
   localparam int IDX_W  = (TIDX_W > MIDX_W) ? TIDX_W : MIDX_W;
   localparam int PB     = PRED_BITS;

   // tables
   logic [31:0]   paddr_mem [TABLE_DEPTH];
   logic [PB-1:0] pval_mem  [TABLE_DEPTH];
   logic [31:0]   maddr_mem [MEET_DEPTH];
   logic [31:0]   mtime_mem [MEET_DEPTH];

   logic [31:0]   prd_addr_ff;
   logic [PB-1:0] prd_val_ff;
   logic [31:0]   mrd_addr_ff;
   logic [31:0]   mrd_time_ff;

   // configuration
   logic [31:0]   own_ff;
   logic [PB-1:0] pinit_ff;
   logic [PB-1:0] gam_ff;
   logic [PB-1:0] beta_ff;

   // captured request and working state
   logic [2:0]        type_ff, type_in;
   logic [31:0]       peer_ff, peer_in;
   logic [31:0]       now_ff, now_in;
   logic [31:0]       eaddr_ff, eaddr_in;
   logic [PB-1:0]     epred_ff, epred_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              hit_ff, hit_in;
   logic [TIDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [PB-1:0]     hit_val_ff, hit_val_in;
   logic [TCNT_W-1:0] pcnt_ff, pcnt_in;
   logic [MCNT_W-1:0] mcnt_ff, mcnt_in;
   logic [PB-1:0]     latch_ff, latch_in;
   logic              armed_ff, armed_in;
   logic [31:0]       d_ff, d_in;
   logic [PB:0]       r_ff, r_in;
   logic [PB-1:0]     base_ff, base_in;
   logic [4:0]        bit_ff, bit_in;
   logic [PB-1:0]     t_ff, t_in;
   logic              ov_ff, ov_in;
   logic [31:0]       oaddr_ff, oaddr_in;
   logic [PB-1:0]     opred_ff, opred_in;
   logic [2:0]        ost_ff, ost_in;
   logic              olast_ff, olast_in;

   // memory write controls
   logic              p_we_a, p_we_v;
   logic [TIDX_W-1:0] p_wa;
   logic [31:0]       p_wd_a;
   logic [PB-1:0]     p_wd_v;
   logic              m_we_a, m_we_t;
   logic [MIDX_W-1:0] m_wa;
   logic [31:0]       m_wd_a;
   logic [31:0]       m_wd_t;

   // arithmetic
   logic [PB-1:0]     upd_k;
   logic [PB:0]       upd_inv;
   logic [2*PB:0]     upd_prod;
   logic [PB:0]       upd_nv;
   logic [2*PB:0]     pow_r_prod;
   logic [2*PB-1:0]   pow_b_prod;
   logic [2*PB:0]     age_prod;
   logic [2*PB-1:0]   t_prod;
   logic              p_full, m_full;
   logic [31:0]       key;
   logic [31:0]       rd_bound;

   // one increment of the old value toward one: P + (1 - P) * k
   assign upd_k    = (type_ff == REQ_HELLO) ? pinit_ff : t_ff;
   assign upd_inv  = PRED_ONE - {1'b0, hit_val_ff};
   assign upd_prod = upd_inv * upd_k;
   assign upd_nv   = {1'b0, hit_val_ff} + upd_prod[2*PB:PB];

   assign pow_r_prod = r_ff * base_ff;
   assign pow_b_prod = base_ff * base_ff;
   assign age_prod   = prd_val_ff * r_ff;
   assign t_prod     = (cmd.op == OP_TMUL1) ? latch_ff * epred_ff : t_ff * beta_ff;

   assign p_full   = (32'(pcnt_ff) >= TABLE_DEPTH);
   assign m_full   = (32'(mcnt_ff) >= MEET_DEPTH);
   assign key      = (type_ff == REQ_ENTRY) ? eaddr_ff : peer_ff;
   assign rd_bound = (32'(pcnt_ff) > MAX_RESULTS) ? 32'(MAX_RESULTS) : 32'(pcnt_ff);

   // status to the controller
   assign sts.req_type   = type_ff;
   assign sts.pred_empty = (pcnt_ff == '0);
   assign sts.meet_empty = (mcnt_ff == '0);
   assign sts.pred_last  = (32'(idx_ff) + 32'd1 >= 32'(pcnt_ff));
   assign sts.meet_last  = (32'(idx_ff) + 32'd1 >= 32'(mcnt_ff));
   assign sts.read_last  = (32'(idx_ff) + 32'd1 >= rd_bound);
   assign sts.armed      = armed_ff;
   assign sts.own_hit    = (eaddr_ff == own_ff);
   assign sts.pow_done   = (bit_ff == 5'd31);
   assign sts.out_busy   = ov_ff & ~rsp_tready;

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {opred_ff, oaddr_ff};
   assign rsp_tuser  = ost_ff;
   assign rsp_tlast  = olast_ff;

   // next-state logic, one operation per cycle
   always_comb begin
      type_in    = type_ff;
      peer_in    = peer_ff;
      now_in     = now_ff;
      eaddr_in   = eaddr_ff;
      epred_in   = epred_ff;
      idx_in     = idx_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_val_in = hit_val_ff;
      pcnt_in    = pcnt_ff;
      mcnt_in    = mcnt_ff;
      latch_in   = latch_ff;
      armed_in   = armed_ff;
      d_in       = d_ff;
      r_in       = r_ff;
      base_in    = base_ff;
      bit_in     = bit_ff;
      t_in       = t_ff;
      ov_in      = ov_ff & ~rsp_tready;
      oaddr_in   = oaddr_ff;
      opred_in   = opred_ff;
      ost_in     = ost_ff;
      olast_in   = olast_ff;
      p_we_a     = 1'b0;
      p_we_v     = 1'b0;
      p_wa       = pcnt_ff[TIDX_W-1:0];
      p_wd_a     = key;
      p_wd_v     = pinit_ff;
      m_we_a     = 1'b0;
      m_we_t     = 1'b0;
      m_wa       = idx_ff[MIDX_W-1:0];
      m_wd_a     = peer_ff;
      m_wd_t     = now_ff;

      case (cmd.op)
         OP_LOAD: begin
            type_in  = req_tuser;
            peer_in  = req_tdata[31:0];
            now_in   = req_tdata[63:32];
            eaddr_in = req_tdata[95:64];
            epred_in = req_tdata[96 +: PB];
            idx_in   = '0;
            hit_in   = 1'b0;
         end
         OP_PCMP: begin
            if (!hit_ff && prd_addr_ff == key) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff[TIDX_W-1:0];
               hit_val_in = prd_val_ff;
            end
            idx_in = idx_ff + 1'b1;
         end
         OP_MCMP: begin
            if (!hit_ff && mrd_addr_ff == peer_ff) begin
               hit_in = 1'b1;
               d_in   = now_ff - mrd_time_ff;
               m_we_t = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
         end
         OP_MEND: begin
            if (!hit_ff) begin
               d_in = now_ff;
               if (!m_full) begin
                  m_wa    = mcnt_ff[MIDX_W-1:0];
                  m_we_a  = 1'b1;
                  m_we_t  = 1'b1;
                  mcnt_in = mcnt_ff + 1'b1;
               end
            end
            r_in    = PRED_ONE;
            base_in = gam_ff;
            bit_in  = '0;
            idx_in  = '0;
            hit_in  = 1'b0;
         end
         OP_POW: begin
            // square and multiply, one exponent bit per step
            if (d_ff[0]) begin
               r_in = pow_r_prod[2*PB:PB];
            end
            base_in = pow_b_prod[2*PB-1:PB];
            d_in    = {1'b0, d_ff[31:1]};
            bit_in  = bit_ff + 1'b1;
         end
         OP_AGE: begin
            if (prd_addr_ff == peer_ff) begin
               if (!hit_ff) begin
                  hit_in     = 1'b1;
                  hit_val_in = prd_val_ff;
               end
            end else begin
               p_wa   = idx_ff[TIDX_W-1:0];
               p_wd_v = age_prod[PB +: PB];
               p_we_v = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
         end
         OP_HELLO: begin
            armed_in = 1'b0;
            ov_in    = 1'b1;
            oaddr_in = peer_ff;
            olast_in = 1'b1;
            if (hit_ff) begin
               p_wa     = hit_idx_ff;
               p_wd_v   = upd_nv[PB-1:0];
               p_we_v   = 1'b1;
               opred_in = upd_nv[PB-1:0];
               ost_in   = ST_UPDATED;
            end else if (!p_full) begin
               p_we_a   = 1'b1;
               p_we_v   = 1'b1;
               pcnt_in  = pcnt_ff + 1'b1;
               opred_in = pinit_ff;
               ost_in   = ST_ADDED;
            end else begin
               opred_in = '0;
               ost_in   = ST_FULL;
            end
         end
         OP_ACK: begin
            armed_in = 1'b1;
            ov_in    = 1'b1;
            oaddr_in = peer_ff;
            olast_in = 1'b1;
            if (hit_ff) begin
               opred_in = hit_val_ff;
               latch_in = hit_val_ff;
               ost_in   = ST_SAME;
            end else if (!p_full) begin
               p_we_a   = 1'b1;
               p_we_v   = 1'b1;
               pcnt_in  = pcnt_ff + 1'b1;
               opred_in = pinit_ff;
               latch_in = pinit_ff;
               ost_in   = ST_ADDED;
            end else begin
               opred_in = '0;
               latch_in = '0;
               ost_in   = ST_FULL;
            end
         end
         OP_ACK2: begin
            armed_in = 1'b1;
            latch_in = hit_ff ? hit_val_ff : '0;
            ov_in    = 1'b1;
            oaddr_in = peer_ff;
            opred_in = hit_ff ? hit_val_ff : '0;
            ost_in   = ST_SAME;
            olast_in = 1'b1;
         end
         OP_TMUL1: t_in = t_prod[PB +: PB];
         OP_TMUL2: t_in = t_prod[PB +: PB];
         OP_TFIN: begin
            ov_in    = 1'b1;
            oaddr_in = eaddr_ff;
            olast_in = 1'b1;
            if (hit_ff) begin
               if (upd_nv > {1'b0, hit_val_ff}) begin
                  p_wa     = hit_idx_ff;
                  p_wd_v   = upd_nv[PB-1:0];
                  p_we_v   = 1'b1;
                  opred_in = upd_nv[PB-1:0];
                  ost_in   = ST_UPDATED;
               end else begin
                  opred_in = hit_val_ff;
                  ost_in   = ST_SAME;
               end
            end else if (!p_full) begin
               p_wd_v   = t_ff;
               p_we_a   = 1'b1;
               p_we_v   = 1'b1;
               pcnt_in  = pcnt_ff + 1'b1;
               opred_in = t_ff;
               ost_in   = ST_ADDED;
            end else begin
               opred_in = '0;
               ost_in   = ST_FULL;
            end
         end
         OP_TSKIP: begin
            ov_in    = 1'b1;
            oaddr_in = eaddr_ff;
            opred_in = '0;
            ost_in   = armed_ff ? ST_OWN : ST_SAME;
            olast_in = 1'b1;
         end
         OP_RDOUT: begin
            ov_in    = 1'b1;
            oaddr_in = prd_addr_ff;
            opred_in = prd_val_ff;
            ost_in   = ST_SAME;
            olast_in = sts.read_last;
            idx_in   = idx_ff + 1'b1;
         end
         OP_EMPTY: begin
            ov_in    = 1'b1;
            oaddr_in = '0;
            opred_in = '0;
            ost_in   = (type_ff == REQ_READ) ? ST_EMPTY : ST_SAME;
            olast_in = 1'b1;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff  <= '0;
         mcnt_ff  <= '0;
         latch_ff <= '0;
         armed_ff <= 1'b0;
         ov_ff    <= 1'b0;
         own_ff   <= '0;
         pinit_ff <= PB'(49152);
         gam_ff   <= PB'(64225);
         beta_ff  <= PB'(16384);
      end else begin
         pcnt_ff  <= pcnt_in;
         mcnt_ff  <= mcnt_in;
         latch_ff <= latch_in;
         armed_ff <= armed_in;
         ov_ff    <= ov_in;
         if (csr_we) begin
            case (csr_index)
               CSR_OWN:   own_ff   <= csr_wdata;
               CSR_PINIT: pinit_ff <= csr_wdata[PB-1:0];
               CSR_GAMMA: gam_ff   <= csr_wdata[PB-1:0];
               CSR_BETA:  beta_ff  <= csr_wdata[PB-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      type_ff    <= type_in;
      peer_ff    <= peer_in;
      now_ff     <= now_in;
      eaddr_ff   <= eaddr_in;
      epred_ff   <= epred_in;
      idx_ff     <= idx_in;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      hit_val_ff <= hit_val_in;
      d_ff       <= d_in;
      r_ff       <= r_in;
      base_ff    <= base_in;
      bit_ff     <= bit_in;
      t_ff       <= t_in;
      oaddr_ff   <= oaddr_in;
      opred_ff   <= opred_in;
      ost_ff     <= ost_in;
      olast_ff   <= olast_in;
   end

   // table memories, one write and one registered read each
   always_ff @(posedge clock) begin
      if (p_we_a) begin
         paddr_mem[p_wa] <= p_wd_a;
      end
      if (p_we_v) begin
         pval_mem[p_wa] <= p_wd_v;
      end
      if (m_we_a) begin
         maddr_mem[m_wa] <= m_wd_a;
      end
      if (m_we_t) begin
         mtime_mem[m_wa] <= m_wd_t;
      end
      prd_addr_ff <= paddr_mem[idx_ff[TIDX_W-1:0]];
      prd_val_ff  <= pval_mem[idx_ff[TIDX_W-1:0]];
      mrd_addr_ff <= maddr_mem[idx_ff[MIDX_W-1:0]];
      mrd_time_ff <= mtime_mem[idx_ff[MIDX_W-1:0]];
   end

endmodule

`default_nettype wire

@@ rtl/core/delivery_predictability_table_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Delivery-predictability table: keeps up to TABLE_DEPTH destinations with a
// Q0.16 predictability and up to MEET_DEPTH peers with their last meeting
// time. One request is worked at a time; each table scan reads its entries
// in turn from memories with one write port and a registered read. A hello,
// hello-ack2 or peer table entry scans the table (an entry, unless skipped,
// first scales its predictability); a hello-ack scans the peers, runs 32
// power steps of square-and-multiply and then the aging scan; a read streams
// at most 16 entries. A finished response waits in an output register while
// the next request is taken. Configuration is to be written by the user only
// while the block is idle; the block itself does not enforce this.

module delivery_predictability_table_core
   import dpt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int MEET_DEPTH  = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // peer_address[31:0], now_seconds[63:32], entry_address[95:64],
   // entry_pred[111:96]
   input  wire logic [111:0] req_tdata,
   // req_type[2:0]
   input  wire logic [2:0]   req_tuser,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_address[31:0], out_pred[47:32]
   output logic [47:0]       rsp_tdata,
   // status[2:0]
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   dpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dpt_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MEET_DEPTH  (MEET_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ rtl/core/dpt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dpt_checker
   import dpt_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // a held response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // block is busy right after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // empty read gives a single final response
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_EMPTY |-> rsp_tlast && rsp_tdata == '0)
      else $error("empty response malformed");

   // own-address skips and table-full drops carry zero predictability
   a_zero_pred: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_OWN || rsp_tuser == ST_FULL)
      |-> rsp_tdata[47:32] == '0 && rsp_tlast)
      else $error("nonzero predictability on skip or drop");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response after reset");

endmodule

bind delivery_predictability_table_core dpt_checker u_dpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
